>>> rtl/core/ile_pkg.sv
package ile_pkg;

	// default list depth
	localparam int CAPACITY_DEF = 32;

	// operation codes
	localparam logic [2:0] OP_INS_AT   = 3'd0;
	localparam logic [2:0] OP_INS_LAST = 3'd1;
	localparam logic [2:0] OP_DEL_AT   = 3'd2;
	localparam logic [2:0] OP_DEL_LAST = 3'd3;
	localparam logic [2:0] OP_READ_AT  = 3'd4;
	localparam logic [2:0] OP_WRITE_AT = 3'd5;
	localparam logic [2:0] OP_FIND     = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD      = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// cell update modes
	localparam logic [1:0] UPD_HOLD  = 2'd0;
	localparam logic [1:0] UPD_INS   = 2'd1;
	localparam logic [1:0] UPD_DEL   = 2'd2;
	localparam logic [1:0] UPD_WRITE = 2'd3;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic       gather;
		logic       find;
		logic [1:0] upd;
	} ctl_t;

endpackage

>>> rtl/core/ile_cell.sv
module ile_cell #(
	parameter int CAPACITY = 32,
	parameter int IDX      = 0,
	parameter int PW       = 6,
	parameter int IW       = 5
) (
	input  logic                clk,
	input  ile_pkg::ctl_t       ctl,
	input  logic [PW-1:0]       tpos,
	input  logic [PW-1:0]       count,
	input  logic [31:0]         item_val,
	input  logic [31:0]         left_val,
	input  logic [31:0]         right_val,
	input  logic                carry_hit_in,
	input  logic [31:0]         carry_val_in,
	input  logic [IW-1:0]       carry_idx_in,
	output logic [31:0]         entry,
	output logic                carry_hit,
	output logic [31:0]         carry_val,
	output logic [IW-1:0]       carry_idx
);
	import ile_pkg::*;

	localparam logic [PW-1:0] IDX_P = PW'(IDX);
	localparam logic [IW-1:0] IDX_I = IW'(IDX);

	logic [31:0]   entry_q;
	logic          carry_hit_q;
	logic [31:0]   carry_val_q;
	logic [IW-1:0] carry_idx_q;
	logic          in_list;
	logic          match;

	assign in_list = (IDX_P < count);

	// this cell answers a read by position or a find by value
	assign match = ctl.find ? (in_list && (entry_q == item_val))
	                        : (in_list && (IDX_P == tpos));

	// pass the first hit down the chain, one cell per cycle
	always_ff @(posedge clk) begin
		if (ctl.gather) begin
			if (carry_hit_in || !match) begin
				carry_hit_q <= carry_hit_in;
				carry_val_q <= carry_val_in;
				carry_idx_q <= carry_idx_in;
			end else begin
				carry_hit_q <= 1'b1;
				carry_val_q <= entry_q;
				carry_idx_q <= IDX_I;
			end
		end
	end

	// shift, overwrite or hold the stored entry
	always_ff @(posedge clk) begin
		case (ctl.upd)
			UPD_INS: begin
				if (IDX_P == tpos) begin
					entry_q <= item_val;
				end else if ((IDX_P > tpos) && (IDX_P <= count)) begin
					entry_q <= left_val;
				end
			end
			UPD_DEL: begin
				if ((IDX_P >= tpos) && ((IDX_P + PW'(1)) < count)) begin
					entry_q <= right_val;
				end
			end
			UPD_WRITE: begin
				if (IDX_P == tpos) begin
					entry_q <= item_val;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry     = entry_q;
	assign carry_hit = carry_hit_q;
	assign carry_val = carry_val_q;
	assign carry_idx = carry_idx_q;

endmodule

>>> rtl/core/indexed_list_engine_core.sv
// Indexed list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Command channel: drive op, position and item_value with start; the command
// transfers at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with result_value,
// found_position, list_length and status; the receiver cannot stall it, so
// results must be captured in that cycle.
// Every entry lives in its own cell; cells shift to their neighbors for insert
// and delete, and overwrite in place for write.
// Insert, append, write and the unused code go from transfer to the finish
// state and then to done. Read, delete and find first pass through the gather
// state, where the first hit walks down the cell chain one cell per cycle
// before the result is formed. busy is high from transfer until the cycle done
// shows; a new command may transfer in the cycle that done is high.
// Reset (arst_n low) empties the list and drops any command in flight; the
// cell contents are not cleared and are only read once written.
module indexed_list_engine_core #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic [5:0]         position,
	input  logic signed [31:0] item_value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [4:0]         found_position,
	output logic [5:0]         list_length,
	output logic [1:0]         status
);
	import ile_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = (CW > 6) ? CW : 6;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_GATHER = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] step_q;
	logic [CW-1:0] count_q;
	logic [2:0]    op_q;
	logic [PW-1:0] tpos_q;
	logic [31:0]   val_q;

	logic          done_q;
	logic [31:0]   res_q;
	logic [4:0]    found_q;
	logic [5:0]    len_q;
	logic [1:0]    st_q;

	logic          accept;
	logic          need_gather;
	logic [PW-1:0] cnt_ext;
	logic [PW-1:0] tpos_in;
	ctl_t          ctl;
	logic [1:0]    upd;
	logic [CW-1:0] cnt_nx;
	logic [PW-1:0] cnt_nx_ext;
	logic [31:0]   res_nx;
	logic [PW-1:0] found_ext;
	logic [1:0]    st_nx;

	logic [31:0]   entry_w     [CAPACITY];
	logic          carry_hit_w [CAPACITY];
	logic [31:0]   carry_val_w [CAPACITY];
	logic [IW-1:0] carry_idx_w [CAPACITY];

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign cnt_ext = PW'(count_q);

	// resolve the tail position for append and delete-last
	always_comb begin
		case (op)
			OP_INS_LAST: tpos_in = cnt_ext;
			OP_DEL_LAST: tpos_in = cnt_ext - PW'(1);
			default:     tpos_in = PW'(position);
		endcase
	end

	assign need_gather = (op == OP_DEL_AT) || (op == OP_DEL_LAST) ||
	                     (op == OP_READ_AT) || (op == OP_FIND);

	// decide status, new length and cell update in the finish cycle
	always_comb begin
		upd       = UPD_HOLD;
		cnt_nx    = count_q;
		res_nx    = 32'd0;
		found_ext = '0;
		st_nx     = ST_OK;
		case (op_q)
			OP_INS_AT, OP_INS_LAST: begin
				if (count_q == CW'(CAPACITY)) begin
					st_nx = ST_FULL;
				end else if (tpos_q > cnt_ext) begin
					st_nx = ST_BAD;
				end else begin
					upd    = UPD_INS;
					cnt_nx = count_q + CW'(1);
				end
			end
			OP_DEL_AT, OP_DEL_LAST: begin
				if ((count_q == '0) || (tpos_q >= cnt_ext)) begin
					st_nx = ST_BAD;
				end else begin
					upd    = UPD_DEL;
					res_nx = carry_val_w[CAPACITY-1];
					cnt_nx = count_q - CW'(1);
				end
			end
			OP_READ_AT: begin
				if (tpos_q >= cnt_ext) begin
					st_nx = ST_BAD;
				end else begin
					res_nx = carry_val_w[CAPACITY-1];
				end
			end
			OP_WRITE_AT: begin
				if (tpos_q >= cnt_ext) begin
					st_nx = ST_BAD;
				end else begin
					upd = UPD_WRITE;
				end
			end
			OP_FIND: begin
				if (carry_hit_w[CAPACITY-1]) begin
					found_ext = PW'(carry_idx_w[CAPACITY-1]);
				end else begin
					st_nx = ST_NOTFOUND;
				end
			end
			default: begin
				st_nx = ST_OK;
			end
		endcase
	end

	assign cnt_nx_ext = PW'(cnt_nx);

	assign ctl.gather = (state_q == S_GATHER);
	assign ctl.find   = (op_q == OP_FIND);
	assign ctl.upd    = (state_q == S_FINISH) ? upd : UPD_HOLD;

	// sequence one command: capture, walk the chain if needed, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= need_gather ? S_GATHER : S_FINISH;
					end
				end
				S_GATHER: begin
					if (step_q == IW'(CAPACITY - 1)) begin
						state_q <= S_FINISH;
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				S_FINISH: begin
					count_q <= cnt_nx;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the command and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			tpos_q <= tpos_in;
			val_q  <= item_value;
		end
		if (state_q == S_FINISH) begin
			res_q   <= res_nx;
			found_q <= found_ext[4:0];
			len_q   <= cnt_nx_ext[5:0];
			st_q    <= st_nx;
		end
	end

	// chain of cells, each holding one list position
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0]   left_w;
		logic [31:0]   right_w;
		logic          hit_in_w;
		logic [31:0]   val_in_w;
		logic [IW-1:0] idx_in_w;

		if (i == 0) begin : g_head
			assign left_w   = 32'd0;
			assign hit_in_w = 1'b0;
			assign val_in_w = 32'd0;
			assign idx_in_w = '0;
		end else begin : g_body
			assign left_w   = entry_w[i-1];
			assign hit_in_w = carry_hit_w[i-1];
			assign val_in_w = carry_val_w[i-1];
			assign idx_in_w = carry_idx_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = 32'd0;
		end else begin : g_next
			assign right_w = entry_w[i+1];
		end

		ile_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i),
			.PW       (PW),
			.IW       (IW)
		) u_cell (
			.clk          (clk),
			.ctl          (ctl),
			.tpos         (tpos_q),
			.count        (cnt_ext),
			.item_val     (val_q),
			.left_val     (left_w),
			.right_val    (right_w),
			.carry_hit_in (hit_in_w),
			.carry_val_in (val_in_w),
			.carry_idx_in (idx_in_w),
			.entry        (entry_w[i]),
			.carry_hit    (carry_hit_w[i]),
			.carry_val    (carry_val_w[i]),
			.carry_idx    (carry_idx_w[i])
		);
	end

	assign done           = done_q;
	assign result_value   = res_q;
	assign found_position = found_q;
	assign list_length    = len_q;
	assign status         = st_q;

endmodule

>>> rtl/core/ile_chk.sv
module ile_chk #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] result_value,
	input logic [4:0]         found_position,
	input logic [5:0]         list_length,
	input logic [1:0]         status
);
	import ile_pkg::*;

	// a transfer always makes the engine busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not raise busy");

	// busy rises only after a transfer
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command transfer");

	// a result shows for one cycle, with the engine free again
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy ##1 !done))
		else $error("result strobe not a single cycle or engine still busy");

	// a full list reports its capacity as length
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL)) |-> (list_length == 6'(CAPACITY)))
		else $error("full status with wrong length");

	// a failed find returns no value and no position
	a_notfound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_NOTFOUND)) |->
		((result_value == 32'sd0) && (found_position == 5'd0)))
		else $error("not-found result carries data");

endmodule

bind indexed_list_engine_core ile_chk #(.CAPACITY(CAPACITY)) u_ile_chk (.*);

>>> verif/list_reply_check.sv
module list_reply_check #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         op,
	input  logic [5:0]         position,
	input  logic signed [31:0] item_value,
	input  logic               done,
	input  logic signed [31:0] result_value,
	input  logic [4:0]         found_position,
	input  logic [5:0]         list_length,
	input  logic [1:0]         status,
	output int                 fail_count,
	output int                 replies_due,
	output int                 model_length,
	output int                 checked,
	output int                 full_seen,
	output int                 miss_seen
);
	import ile_pkg::*;

	typedef struct packed {
		logic signed [31:0] value;
		logic [4:0]         found;
		logic [5:0]         length;
		logic [1:0]         status;
	} reply_t;

	// shadow copy of the list
	logic [31:0] list_mem [CAPACITY];
	int          list_len;

	// replies owed by the block, oldest first
	reply_t      replies_q [$];

	int          n_fail;
	int          n_checked;
	int          n_full;
	int          n_miss;

	// apply one command to the shadow list and return the reply it earns
	function automatic reply_t step_list(logic [2:0] code, logic [5:0] pos,
			logic signed [31:0] val);
		reply_t r;
		int     at;
		r = '{value: '0, found: '0, length: '0, status: ST_OK};
		at = pos;
		case (code)
		OP_INS_AT, OP_INS_LAST: begin
			if (code == OP_INS_LAST)
				at = list_len;
			// full is checked ahead of the position
			if (list_len >= CAPACITY) begin
				r.status = ST_FULL;
			end else if (at > list_len) begin
				r.status = ST_BAD;
			end else begin
				for (int i = list_len; i > at; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[at] = val;
				list_len++;
			end
		end
		OP_DEL_AT, OP_DEL_LAST: begin
			if (list_len == 0) begin
				r.status = ST_BAD;
			end else begin
				if (code == OP_DEL_LAST)
					at = list_len - 1;
				if (at >= list_len) begin
					r.status = ST_BAD;
				end else begin
					r.value = list_mem[at];
					for (int i = at; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
		end
		OP_READ_AT: begin
			if (at >= list_len)
				r.status = ST_BAD;
			else
				r.value = list_mem[at];
		end
		OP_WRITE_AT: begin
			if (at >= list_len)
				r.status = ST_BAD;
			else
				list_mem[at] = val;
		end
		OP_FIND: begin
			// first match wins
			r.status = ST_NOTFOUND;
			for (int i = 0; i < list_len; i++) begin
				if (list_mem[i] == val) begin
					r.found = i[4:0];
					r.status = ST_OK;
					break;
				end
			end
		end
		default: begin
			// unused code: no change, plain ok reply
		end
		endcase
		r.length = list_len[5:0];
		return r;
	endfunction

	// compare result transfers, then predict on command transfers
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			replies_q.delete();
			list_len = 0;
			n_fail = 0;
			n_checked = 0;
			n_full = 0;
			n_miss = 0;
			fail_count <= 0;
			replies_due <= 0;
			model_length <= 0;
			checked <= 0;
			full_seen <= 0;
			miss_seen <= 0;
		end else begin
			// the result belongs to an older command than one transferring now
			if (done) begin
				if (replies_q.size() == 0) begin
					$error("result with no command pending: value %0d, status %0d",
						result_value, status);
					n_fail++;
				end else begin
					want = replies_q.pop_front();
					n_checked++;
					if (want.status == ST_FULL)
						n_full++;
					if (want.status == ST_NOTFOUND)
						n_miss++;
					if (result_value !== want.value) begin
						$error("result_value: expected %0d, got %0d",
							want.value, result_value);
						n_fail++;
					end
					if (found_position !== want.found) begin
						$error("found_position: expected %0d, got %0d",
							want.found, found_position);
						n_fail++;
					end
					if (list_length !== want.length) begin
						$error("list_length: expected %0d, got %0d",
							want.length, list_length);
						n_fail++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						n_fail++;
					end
				end
			end
			if (start && !busy)
				replies_q.push_back(step_list(op, position, item_value));
			fail_count <= n_fail;
			replies_due <= replies_q.size();
			model_length <= list_len;
			checked <= n_checked;
			full_seen <= n_full;
			miss_seen <= n_miss;
		end
	end

endmodule

>>> verif/tb_top.sv
module tb_top;
	import ile_pkg::*;

	// unused op code, no operation
	localparam logic [2:0] OP_NOP = 3'd7;
	localparam int N_RANDOM = 1330;
	localparam int LATENCY = CAPACITY_DEF + 2;
	localparam int QUIET_LIMIT = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         op = '0;
	logic [5:0]         position = '0;
	logic signed [31:0] item_value = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] result_value;
	logic [4:0]         found_position;
	logic [5:0]         list_length;
	logic [1:0]         status;

	int fail_count;
	int replies_due;
	int model_length;
	int checked;
	int full_seen;
	int miss_seen;
	int n_sent = 0;
	int quiet_cycles = 0;

	always #10 clk = ~clk;

	indexed_list_engine_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.result_value   (result_value),
		.found_position (found_position),
		.list_length    (list_length),
		.status         (status)
	);

	list_reply_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.result_value   (result_value),
		.found_position (found_position),
		.list_length    (list_length),
		.status         (status),
		.fail_count     (fail_count),
		.replies_due    (replies_due),
		.model_length   (model_length),
		.checked        (checked),
		.full_seen      (full_seen),
		.miss_seen      (miss_seen)
	);

	// end the run when no transfer of either kind happens for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// hold the command until it transfers; start stays high on return
	task automatic issue(input logic [2:0] code, input logic [5:0] pos,
			input logic signed [31:0] val);
		start <= 1'b1;
		op <= code;
		position <= pos;
		item_value <= val;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	// drop start for a while and scramble the idle fields
	task automatic rest(input int cycles);
		start <= 1'b0;
		op <= 3'($urandom);
		position <= 6'($urandom);
		item_value <= $urandom;
		repeat (cycles) @(posedge clk);
	endtask

	// hold off until every owed result has arrived
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (replies_due != 0);
	endtask

	function automatic logic [2:0] choose_op(bit grow);
		int r;
		r = $urandom_range(0, 99);
		if (r < 1)
			return OP_NOP;
		if (r < 13)
			return OP_READ_AT;
		if (r < 24)
			return OP_WRITE_AT;
		if (r < 38)
			return OP_FIND;
		if (grow) begin
			if (r < 75)
				return OP_INS_AT;
			if (r < 90)
				return OP_INS_LAST;
			if (r < 96)
				return OP_DEL_AT;
			return OP_DEL_LAST;
		end
		if (r < 50)
			return OP_INS_AT;
		if (r < 56)
			return OP_INS_LAST;
		if (r < 80)
			return OP_DEL_AT;
		return OP_DEL_LAST;
	endfunction

	// mostly legal positions, some anywhere in the field
	function automatic logic [5:0] choose_pos(logic [2:0] code, int len);
		if ($urandom_range(0, 9) == 0)
			return 6'($urandom_range(0, 63));
		if (code == OP_INS_AT)
			return 6'($urandom_range(0, len));
		if (len > 0)
			return 6'($urandom_range(0, len - 1));
		return 6'd0;
	endfunction

	// a small pool of values makes finds hit and duplicates appear
	function automatic logic signed [31:0] choose_val();
		if ($urandom_range(0, 9) >= 6)
			return $urandom;
		case ($urandom_range(0, 7))
		0: return 32'sd0;
		1: return 32'sd1;
		2: return -32'sd1;
		3: return 32'h7fff_ffff;
		4: return 32'h8000_0000;
		5: return 32'sd5;
		6: return 32'sd100;
		default: return -32'sd100;
		endcase
	endfunction

	initial begin
		logic [2:0] code;
		bit         grow;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		issue(OP_FIND, 6'd0, 32'sd0);
		issue(OP_DEL_AT, 6'd0, 32'sd0);
		issue(OP_DEL_LAST, 6'd0, 32'sd0);
		issue(OP_READ_AT, 6'd0, 32'sd0);
		issue(OP_WRITE_AT, 6'd0, 32'sd9);
		issue(OP_INS_AT, 6'd1, 32'sd3);
		// build a short list with the value extremes
		issue(OP_INS_AT, 6'd0, 32'h8000_0000);
		issue(OP_INS_LAST, 6'd63, 32'h7fff_ffff);
		issue(OP_INS_LAST, 6'd0, -32'sd1);
		issue(OP_INS_AT, 6'd1, 32'sd0);
		issue(OP_INS_AT, 6'd4, 32'sd7);
		issue(OP_INS_AT, 6'd63, 32'sd8);
		// reads and writes in and out of range
		issue(OP_READ_AT, 6'd0, 32'sd0);
		issue(OP_READ_AT, 6'd4, 32'sd0);
		issue(OP_READ_AT, 6'd5, 32'sd0);
		issue(OP_READ_AT, 6'd32, 32'sd0);
		issue(OP_WRITE_AT, 6'd2, -32'sd1);
		issue(OP_WRITE_AT, 6'd5, 32'sd1);
		// first match, miss, head match
		issue(OP_FIND, 6'd0, -32'sd1);
		issue(OP_FIND, 6'd0, 32'sd12345);
		issue(OP_FIND, 6'd0, 32'h8000_0000);
		// removals and the unused code
		issue(OP_DEL_AT, 6'd1, 32'sd0);
		issue(OP_DEL_LAST, 6'd0, 32'sd0);
		issue(OP_DEL_AT, 6'd40, 32'sd0);
		issue(OP_NOP, 6'd63, 32'h5a5a_a5a5);
		drain();

		// alternate growing and shrinking phases so full and empty recur
		for (int i = 0; i < N_RANDOM; i++) begin
			grow = ((i / 90) % 2 == 0);
			code = choose_op(grow);
			issue(code, choose_pos(code, model_length), choose_val());
			if (i < N_RANDOM - 150 && (i / 40) % 3 != 2 && $urandom_range(0, 3) == 0)
				rest($urandom_range(1, 14));
			if (i % 300 == 299 && i < N_RANDOM - 150)
				drain();
		end
		start <= 1'b0;

		// wait out the remaining results and the longest latency
		do @(posedge clk); while (replies_due != 0);
		repeat (LATENCY + 4) @(posedge clk);

		$display("Sent %0d list commands over all op codes, %0d results checked.",
			n_sent, checked);
		$display("The list hit capacity %0d times and %0d finds came up empty.",
			full_seen, miss_seen);
		if (fail_count == 0 && replies_due == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
